[src/iaf_pkg.sv]
// Shared types, operation codes and decode helpers for the integer ALU unit.
// No dependencies.
package iaf_pkg;

   localparam int unsigned XLEN = 32;

   localparam logic [5:0] OP_ADD       = 6'd0;
   localparam logic [5:0] OP_ADDC      = 6'd1;
   localparam logic [5:0] OP_ADDE      = 6'd2;
   localparam logic [5:0] OP_ADDI      = 6'd3;
   localparam logic [5:0] OP_ADDIC     = 6'd4;
   localparam logic [5:0] OP_ADDIC_DOT = 6'd5;
   localparam logic [5:0] OP_ADDIS     = 6'd6;
   localparam logic [5:0] OP_ADDME     = 6'd7;
   localparam logic [5:0] OP_ADDZE     = 6'd8;
   localparam logic [5:0] OP_SUBF      = 6'd9;
   localparam logic [5:0] OP_SUBFC     = 6'd10;
   localparam logic [5:0] OP_SUBFE     = 6'd11;
   localparam logic [5:0] OP_SUBFIC    = 6'd12;
   localparam logic [5:0] OP_SUBFME    = 6'd13;
   localparam logic [5:0] OP_SUBFZE    = 6'd14;
   localparam logic [5:0] OP_AND       = 6'd15;
   localparam logic [5:0] OP_XORIS     = 6'd25;
   localparam logic [5:0] OP_CNTLZW    = 6'd26;
   localparam logic [5:0] OP_MULHW     = 6'd27;
   localparam logic [5:0] OP_MULLI     = 6'd28;
   localparam logic [5:0] OP_MULLW     = 6'd29;
   localparam logic [5:0] OP_NEG       = 6'd30;
   localparam logic [5:0] OP_RLWIMI    = 6'd31;
   localparam logic [5:0] OP_RLWINM    = 6'd32;
   localparam logic [5:0] OP_RLWNM     = 6'd33;

   localparam logic [2:0] CLS_NONE  = 3'd0;
   localparam logic [2:0] CLS_ADD   = 3'd1;
   localparam logic [2:0] CLS_LOGIC = 3'd2;
   localparam logic [2:0] CLS_CLZ   = 3'd3;
   localparam logic [2:0] CLS_MUL   = 3'd4;
   localparam logic [2:0] CLS_NEG   = 3'd5;
   localparam logic [2:0] CLS_ROT   = 3'd6;

   localparam logic [3:0] LK_AND   = 4'd0;
   localparam logic [3:0] LK_ANDC  = 4'd1;
   localparam logic [3:0] LK_ANDI  = 4'd2;
   localparam logic [3:0] LK_ANDIS = 4'd3;
   localparam logic [3:0] LK_OR    = 4'd4;
   localparam logic [3:0] LK_ORC   = 4'd5;
   localparam logic [3:0] LK_ORI   = 4'd6;
   localparam logic [3:0] LK_ORIS  = 4'd7;
   localparam logic [3:0] LK_XOR   = 4'd8;
   localparam logic [3:0] LK_XORI  = 4'd9;
   localparam logic [3:0] LK_XORIS = 4'd10;

   localparam logic [31:0] SIGN_BIT = 32'h8000_0000;
   localparam logic [31:0] ALL_ONES = 32'hffff_ffff;

   typedef struct packed {
      logic ca;
      logic ext;
      logic imm;
      logic chk;
      logic dot;
      logic shi;
      logic zero;
      logic m1;
      logic zra;
      logic sub;
   } add_kind_type;

   typedef struct packed {
      logic [5:0]   op;
      logic [4:0]   dest_reg;
      logic [4:0]   src_a_reg;
      logic [4:0]   src_b_reg;
      logic [15:0]  imm16;
      logic [4:0]   shift_amount;
      logic [4:0]   mask_begin;
      logic [4:0]   mask_end;
      logic         oe;
      logic         rc;
      logic [2:0]   cls;
      add_kind_type ak;
      logic [3:0]   lk;
   } dec_type;

   typedef struct packed {
      logic [4:0]  written_reg;
      logic [31:0] result;
      logic [3:0]  cr0_out;
      logic        so_out;
      logic        ov_out;
      logic        ca_out;
      logic        cr_written;
   } rsp_type;

   function automatic add_kind_type add_kind(input logic [5:0] op);
      add_kind_type k;
      k = '0;
      case (op)
         OP_ADD:       begin k.chk = 1'b1; end
         OP_ADDC:      begin k.ca = 1'b1; k.chk = 1'b1; end
         OP_ADDE:      begin k.ext = 1'b1; k.ca = 1'b1; k.chk = 1'b1; end
         OP_ADDI:      begin k.imm = 1'b1; k.zra = 1'b1; end
         OP_ADDIC:     begin k.imm = 1'b1; k.ca = 1'b1; end
         OP_ADDIC_DOT: begin k.imm = 1'b1; k.ca = 1'b1; k.dot = 1'b1; end
         OP_ADDIS:     begin k.imm = 1'b1; k.shi = 1'b1; k.zra = 1'b1; end
         OP_ADDME: begin
            k.chk = 1'b1; k.ca = 1'b1; k.ext = 1'b1; k.m1 = 1'b1;
         end
         OP_ADDZE: begin
            k.chk = 1'b1; k.ca = 1'b1; k.ext = 1'b1; k.zero = 1'b1;
         end
         OP_SUBF:      begin k.sub = 1'b1; k.chk = 1'b1; end
         OP_SUBFC:     begin k.sub = 1'b1; k.ca = 1'b1; k.chk = 1'b1; end
         OP_SUBFE: begin
            k.sub = 1'b1; k.ext = 1'b1; k.ca = 1'b1; k.chk = 1'b1;
         end
         OP_SUBFIC:    begin k.sub = 1'b1; k.imm = 1'b1; k.ca = 1'b1; end
         OP_SUBFME: begin
            k.sub = 1'b1; k.m1 = 1'b1; k.ext = 1'b1; k.ca = 1'b1; k.chk = 1'b1;
         end
         OP_SUBFZE: begin
            k.sub = 1'b1; k.zero = 1'b1; k.ext = 1'b1; k.ca = 1'b1; k.chk = 1'b1;
         end
         default: k = '0;
      endcase
      return k;
   endfunction

endpackage

[src/ppc_integer_alu_with_flags_unit.sv]
// Top level of the 32-bit integer ALU with CR0 and XER flags.
// Depends on iaf_pkg, iaf_front, iaf_back and iaf_fifo.
//
// Takes one decoded instruction per cycle while not full and delivers one
// result item per instruction, in order, from the register-read register to
// the result queue; sustained rate is one item per clock unless that queue
// is full, with one multiply, one add, registered RAM reads and a one-deep bypass.
module ppc_integer_alu_with_flags_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [5:0]  req_op,
   input  logic [4:0]  req_dest_reg,
   input  logic [4:0]  req_src_a_reg,
   input  logic [4:0]  req_src_b_reg,
   input  logic [15:0] req_imm16,
   input  logic [4:0]  req_shift_amount,
   input  logic [4:0]  req_mask_begin,
   input  logic [4:0]  req_mask_end,
   input  logic        req_oe,
   input  logic        req_rc,
   output logic        empty,
   input  logic        pop,
   output logic [4:0]  rsp_written_reg,
   output logic [31:0] rsp_result,
   output logic [3:0]  rsp_cr0_out,
   output logic        rsp_so_out,
   output logic        rsp_ov_out,
   output logic        rsp_ca_out,
   output logic        rsp_cr_written
);
   import iaf_pkg::*;

   dec_type head;
   logic    head_empty, head_pop;
   rsp_type ex_item, rsp;
   logic    ex_push, rsp_full;

   iaf_front u_front (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .op(req_op), .dest_reg(req_dest_reg), .src_a_reg(req_src_a_reg),
      .src_b_reg(req_src_b_reg), .imm16(req_imm16),
      .shift_amount(req_shift_amount), .mask_begin(req_mask_begin),
      .mask_end(req_mask_end), .oe(req_oe), .rc(req_rc),
      .pop(head_pop), .head(head), .empty(head_empty)
   );

   iaf_back u_back (
      .clock(clock), .reset(reset),
      .in_item(head), .in_valid(!head_empty), .in_pop(head_pop),
      .out_item(ex_item), .out_push(ex_push), .out_full(rsp_full)
   );

   iaf_fifo #(.WIDTH($bits(rsp_type))) u_rsp_q (
      .clock(clock), .reset(reset),
      .push(ex_push), .push_data(ex_item), .full(rsp_full),
      .pop(pop), .pop_data(rsp), .empty(empty)
   );

   assign rsp_written_reg = rsp.written_reg;
   assign rsp_result      = rsp.result;
   assign rsp_cr0_out     = rsp.cr0_out;
   assign rsp_so_out      = rsp.so_out;
   assign rsp_ov_out      = rsp.ov_out;
   assign rsp_ca_out      = rsp.ca_out;
   assign rsp_cr_written  = rsp.cr_written;

`ifndef NO_ASSERTIONS
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      rsp_full |-> !ex_push) else $error("item pushed into full result queue");
   a_cr_so: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_cr_written) |-> (rsp_cr0_out[0] == rsp_so_out))
      else $error("CR0 SO differs from XER SO");
   a_ov_so: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_ov_out) |-> rsp_so_out) else $error("OV set without SO");
`endif
endmodule

[src/iaf_fifo.sv]
// Two-entry item queue with push/full and pop/empty sides.
// Depends on nothing.
module iaf_fifo #(
   parameter int unsigned WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   logic [WIDTH-1:0] mem_ff [2];
   logic             wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full     = (cnt_ff == 2'd2);
   assign empty    = (cnt_ff == 2'd0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rp_ff];

   always_comb begin
      wp_in  = wp_ff ^ do_push;
      rp_in  = rp_ff ^ do_pop;
      cnt_in = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wp_ff] <= push_data;
      end
   end
endmodule

[src/iaf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module iaf_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   assign rdata = rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end
endmodule

[src/iaf_front.sv]
// Front end: classifies incoming instructions and queues them for execution.
// Depends on iaf_pkg and iaf_fifo.
module iaf_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic [5:0]       op,
   input  logic [4:0]       dest_reg,
   input  logic [4:0]       src_a_reg,
   input  logic [4:0]       src_b_reg,
   input  logic [15:0]      imm16,
   input  logic [4:0]       shift_amount,
   input  logic [4:0]       mask_begin,
   input  logic [4:0]       mask_end,
   input  logic             oe,
   input  logic             rc,
   input  logic             pop,
   output iaf_pkg::dec_type head,
   output logic             empty
);
   import iaf_pkg::*;

   dec_type d;

   always_comb begin
      d              = '0;
      d.op           = op;
      d.dest_reg     = dest_reg;
      d.src_a_reg    = src_a_reg;
      d.src_b_reg    = src_b_reg;
      d.imm16        = imm16;
      d.shift_amount = shift_amount;
      d.mask_begin   = mask_begin;
      d.mask_end     = mask_end;
      d.oe           = oe;
      d.rc           = rc;
      d.ak           = add_kind(op);
      d.lk           = 4'(op - OP_AND);
      if (op <= OP_SUBFZE) begin
         d.cls = CLS_ADD;
      end else if (op <= OP_XORIS) begin
         d.cls = CLS_LOGIC;
      end else if (op == OP_CNTLZW) begin
         d.cls = CLS_CLZ;
      end else if (op <= OP_MULLW) begin
         d.cls = CLS_MUL;
      end else if (op == OP_NEG) begin
         d.cls = CLS_NEG;
      end else if (op <= OP_RLWNM) begin
         d.cls = CLS_ROT;
      end else begin
         d.cls = CLS_NONE;
      end
   end

   iaf_fifo #(.WIDTH($bits(dec_type))) u_q (
      .clock(clock), .reset(reset),
      .push(push), .push_data(d), .full(full),
      .pop(pop), .pop_data(head), .empty(empty)
   );
endmodule

[src/iaf_back.sv]
// Back end: register read stage with bypass, then execute and write-back.
// Depends on iaf_pkg and iaf_ram.
module iaf_back (
   input  logic             clock,
   input  logic             reset,
   input  iaf_pkg::dec_type in_item,
   input  logic             in_valid,
   output logic             in_pop,
   output iaf_pkg::rsp_type out_item,
   output logic             out_push,
   input  logic             out_full
);
   import iaf_pkg::*;

   logic        r_valid_ff, r_valid_in;
   dec_type     r_item_ff;
   logic [2:0]  byp_sel_ff, byp_sel_in;
   logic [31:0] byp_data_ff;
   logic [2:0]  gv_hit_ff, gv_hit_in;
   logic [31:0] gv_ff, gv_in;
   logic [3:0]  cr0_ff, cr0_in;
   logic        so_ff, so_in, ov_ff, ov_in, ca_ff, ca_in;
   logic [31:0] ram_a, ram_b, ram_d, va, vb, vd;
   logic        load, consume, wr_en, wr, rec;
   logic [31:0] res;

   assign consume    = r_valid_ff && !out_full;
   assign load       = in_valid && (!r_valid_ff || consume);
   assign in_pop     = load;
   assign out_push   = consume;
   assign wr_en      = consume && wr;
   assign r_valid_in = load ? 1'b1 : (consume ? 1'b0 : r_valid_ff);

   always_comb begin
      byp_sel_in[0] = wr_en && (r_item_ff.dest_reg == in_item.src_a_reg);
      byp_sel_in[1] = wr_en && (r_item_ff.dest_reg == in_item.src_b_reg);
      byp_sel_in[2] = wr_en && (r_item_ff.dest_reg == in_item.dest_reg);
      gv_hit_in[0]  = gv_ff[in_item.src_a_reg];
      gv_hit_in[1]  = gv_ff[in_item.src_b_reg];
      gv_hit_in[2]  = gv_ff[in_item.dest_reg];
      gv_in         = gv_ff;
      if (wr_en) begin
         gv_in[r_item_ff.dest_reg] = 1'b1;
      end
   end

   iaf_ram #(.WIDTH(32), .DEPTH(32)) u_ram_a (
      .clock(clock), .we(wr_en), .waddr(r_item_ff.dest_reg), .wdata(res),
      .re(load), .raddr(in_item.src_a_reg), .rdata(ram_a)
   );
   iaf_ram #(.WIDTH(32), .DEPTH(32)) u_ram_b (
      .clock(clock), .we(wr_en), .waddr(r_item_ff.dest_reg), .wdata(res),
      .re(load), .raddr(in_item.src_b_reg), .rdata(ram_b)
   );
   iaf_ram #(.WIDTH(32), .DEPTH(32)) u_ram_d (
      .clock(clock), .we(wr_en), .waddr(r_item_ff.dest_reg), .wdata(res),
      .re(load), .raddr(in_item.dest_reg), .rdata(ram_d)
   );

   assign va = byp_sel_ff[0] ? byp_data_ff : (gv_hit_ff[0] ? ram_a : 32'd0);
   assign vb = byp_sel_ff[1] ? byp_data_ff : (gv_hit_ff[1] ? ram_b : 32'd0);
   assign vd = byp_sel_ff[2] ? byp_data_ff : (gv_hit_ff[2] ? ram_d : 32'd0);

   // execute
   always_comb begin
      logic [31:0] x, y, simm, m, hi, lo, r;
      logic [32:0] sum;
      logic        cin, so_n, ov_n, ca_n;
      logic [63:0] p;
      logic [4:0]  n;
      logic [63:0] rr;
      logic [3:0]  cmp;
      dec_type     it;
      it   = r_item_ff;
      simm = {{16{it.imm16[15]}}, it.imm16};
      so_n = so_ff;
      ov_n = ov_ff;
      ca_n = ca_ff;
      res  = vd;
      wr   = 1'b1;
      rec  = 1'b0;
      x    = '0;
      y    = '0;
      sum  = '0;
      cin  = 1'b0;
      p    = '0;
      m    = '0;
      hi   = '0;
      lo   = '0;
      r    = '0;
      n    = '0;
      rr   = '0;
      cmp  = '0;
      case (it.cls)
         CLS_ADD: begin
            x = (it.ak.zra && it.src_a_reg == 5'd0) ? 32'd0 : va;
            if (it.ak.sub) x = ~x;
            if (it.ak.imm) y = simm;
            else if (it.ak.zero) y = 32'd0;
            else if (it.ak.m1) y = ALL_ONES;
            else y = vb;
            if (it.ak.shi) y = {y[15:0], 16'd0};
            cin = it.ak.ext ? ca_ff : it.ak.sub;
            sum = {1'b0, x} + {1'b0, y} + {32'd0, cin};
            res = sum[31:0];
            if (it.ak.ca) ca_n = sum[32];
            if (it.ak.chk && it.oe) begin
               ov_n = ((x ^ res) & (y ^ res)) >> 31 != 32'd0;
               so_n = so_ff | ov_n;
            end
            rec = it.ak.dot || (it.ak.chk && it.rc);
         end
         CLS_LOGIC: begin
            if (it.lk == LK_ANDI || it.lk == LK_ORI || it.lk == LK_XORI)
               y = {16'd0, it.imm16};
            else if (it.lk == LK_ANDIS || it.lk == LK_ORIS || it.lk == LK_XORIS)
               y = {it.imm16, 16'd0};
            else
               y = vb;
            if (it.lk == LK_ANDC || it.lk == LK_ORC) y = ~y;
            if (it.lk <= LK_ANDIS) res = va & y;
            else if (it.lk <= LK_ORIS) res = va | y;
            else res = va ^ y;
            if (it.lk == LK_ANDI || it.lk == LK_ANDIS) rec = 1'b1;
            else if (it.lk == LK_AND || it.lk == LK_ANDC || it.lk == LK_OR ||
                     it.lk == LK_ORC || it.lk == LK_XOR) rec = it.rc;
         end
         CLS_CLZ: begin
            res = 32'd32;
            for (int i = 0; i < 32; i++) begin
               if (va[i]) res = 32'(31 - i);
            end
            rec = it.rc;
         end
         CLS_MUL: begin
            p = 64'($signed(va) * $signed(it.op == OP_MULLI ? simm : vb));
            if (it.op == OP_MULHW) begin
               res = p[63:32];
               rec = it.rc;
            end else begin
               res = p[31:0];
               if (it.op == OP_MULLW) begin
                  rec = it.rc;
                  if (it.oe) begin
                     ov_n = !((p[63:31] == '0) || (p[63:31] == '1));
                     so_n = so_ff | ov_n;
                  end
               end
            end
         end
         CLS_NEG: begin
            res = 32'd0 - va;
            if (it.oe) begin
               ov_n = (va == SIGN_BIT);
               so_n = so_ff | ov_n;
            end
            rec = it.rc;
         end
         CLS_ROT: begin
            n  = (it.op == OP_RLWNM) ? vb[4:0] : it.shift_amount;
            rr = {va, va} << n;
            r  = rr[63:32];
            hi = ALL_ONES >> it.mask_begin;
            lo = ALL_ONES << (5'd31 - it.mask_end);
            m  = (it.mask_begin <= it.mask_end) ? (hi & lo) : (hi | lo);
            res = (it.op == OP_RLWIMI) ? ((r & m) | (vd & ~m)) : (r & m);
            rec = it.rc;
         end
         default: wr = 1'b0;
      endcase

      cr0_in = cr0_ff;
      so_in  = so_ff;
      ov_in  = ov_ff;
      ca_in  = ca_ff;
      if (wr) begin
         so_in = so_n;
         ov_in = ov_n;
         ca_in = ca_n;
         if (rec) begin
            if (res == 32'd0) cmp = 4'b0010;
            else if (res[31]) cmp = 4'b1000;
            else cmp = 4'b0100;
            cr0_in = cmp | {3'd0, so_n};
         end
      end
      out_item.written_reg = it.dest_reg;
      out_item.result      = res;
      out_item.cr0_out     = cr0_in;
      out_item.so_out      = so_in;
      out_item.ov_out      = ov_in;
      out_item.ca_out      = ca_in;
      out_item.cr_written  = wr && rec;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r_valid_ff <= 1'b0;
         gv_ff      <= '0;
         cr0_ff     <= '0;
         so_ff      <= 1'b0;
         ov_ff      <= 1'b0;
         ca_ff      <= 1'b0;
      end else begin
         r_valid_ff <= r_valid_in;
         gv_ff      <= gv_in;
         if (consume) begin
            cr0_ff <= cr0_in;
            so_ff  <= so_in;
            ov_ff  <= ov_in;
            ca_ff  <= ca_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         r_item_ff   <= in_item;
         byp_sel_ff  <= byp_sel_in;
         byp_data_ff <= res;
         gv_hit_ff   <= gv_hit_in;
      end
   end
endmodule

[tb/tb_ppc_integer_alu_with_flags_unit.sv]
// Testbench for the integer ALU with CR0/XER flags: random and directed
// instructions checked against an in-bench model of the register file and flags.
// Depends on iaf_pkg and the ppc_integer_alu_with_flags_unit RTL.
`timescale 1ns / 100ps

module tb_ppc_integer_alu_with_flags_unit;
   import iaf_pkg::*;

   typedef struct packed {
      logic [5:0]  op;
      logic [4:0]  rd;
      logic [4:0]  ra;
      logic [4:0]  rb;
      logic [15:0] imm;
      logic [4:0]  sh;
      logic [4:0]  mb;
      logic [4:0]  me;
      logic        oe;
      logic        rc;
   } instr_type;

   localparam logic [5:0] OP_LAST = OP_RLWNM;
   localparam int unsigned CYCLE_LIMIT = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        pop = 1'b0;
   logic        full, empty;
   instr_type   drv = '0;
   logic [4:0]  rsp_written_reg;
   logic [31:0] rsp_result;
   logic [3:0]  rsp_cr0_out;
   logic        rsp_so_out, rsp_ov_out, rsp_ca_out, rsp_cr_written;

   ppc_integer_alu_with_flags_unit dut (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .req_op(drv.op), .req_dest_reg(drv.rd), .req_src_a_reg(drv.ra),
      .req_src_b_reg(drv.rb), .req_imm16(drv.imm), .req_shift_amount(drv.sh),
      .req_mask_begin(drv.mb), .req_mask_end(drv.me), .req_oe(drv.oe),
      .req_rc(drv.rc), .empty(empty), .pop(pop),
      .rsp_written_reg(rsp_written_reg), .rsp_result(rsp_result),
      .rsp_cr0_out(rsp_cr0_out), .rsp_so_out(rsp_so_out),
      .rsp_ov_out(rsp_ov_out), .rsp_ca_out(rsp_ca_out),
      .rsp_cr_written(rsp_cr_written)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   instr_type   pending_instrs[$];
   rsp_type     expected_writebacks[$];
   logic [31:0] gpr[32];
   logic [3:0]  cr0;
   logic        xso, xov, xca;
   int unsigned errors = 0;
   int unsigned cycles = 0;
   int unsigned checked = 0;
   int unsigned dot_count = 0;
   bit          calm = 1'b0;
   bit          hold_off = 1'b0;
   bit          drain_pause = 1'b0;
   bit          stim_done = 1'b0;

   function automatic logic [31:0] rot_mask(input logic [4:0] mb, input logic [4:0] me);
      logic [31:0] hi, lo;
      hi = ALL_ONES >> mb;
      lo = ALL_ONES << (5'd31 - me);
      return (mb <= me) ? (hi & lo) : (hi | lo);
   endfunction

   function automatic rsp_type execute_instr(input instr_type it);
      rsp_type        r;
      add_kind_type   k;
      logic [31:0]    x, y, s, res, m, rot;
      logic [32:0]    sum;
      logic signed [63:0] p;
      logic [31:0]    simm;
      logic [3:0]     lk;
      logic           rec, wr;
      int             n;
      simm = {{16{it.imm[15]}}, it.imm};
      res = gpr[it.rd];
      rec = 1'b0;
      wr = 1'b1;
      if (it.op <= OP_SUBFZE) begin
         k = add_kind(it.op);
         x = (k.zra && it.ra == 5'd0) ? 32'd0 : gpr[it.ra];
         if (k.sub) x = ~x;
         if (k.imm) y = simm;
         else if (k.zero) y = 32'd0;
         else if (k.m1) y = ALL_ONES;
         else y = gpr[it.rb];
         if (k.shi) y = y << 16;
         sum = {1'b0, x} + {1'b0, y} + (k.ext ? xca : k.sub);
         res = sum[31:0];
         if (k.ca) xca = sum[32];
         if (k.chk && it.oe) begin
            xov = (x[31] ^ res[31]) & (y[31] ^ res[31]);
            xso |= xov;
         end
         rec = k.dot || (k.chk && it.rc);
      end else if (it.op <= OP_XORIS) begin
         lk = 4'(it.op - OP_AND);
         s = gpr[it.ra];
         if (lk == LK_ANDI || lk == LK_ORI || lk == LK_XORI) y = {16'd0, it.imm};
         else if (lk == LK_ANDIS || lk == LK_ORIS || lk == LK_XORIS) y = {it.imm, 16'd0};
         else y = gpr[it.rb];
         if (lk == LK_ANDC || lk == LK_ORC) y = ~y;
         if (lk <= LK_ANDIS) res = s & y;
         else if (lk <= LK_ORIS) res = s | y;
         else res = s ^ y;
         if (lk == LK_ANDI || lk == LK_ANDIS) rec = 1'b1;
         else if (lk == LK_AND || lk == LK_ANDC || lk == LK_OR || lk == LK_ORC
                  || lk == LK_XOR) rec = it.rc;
      end else if (it.op == OP_CNTLZW) begin
         n = 32;
         for (int i = 0; i < 32; i++) if (gpr[it.ra][i]) n = 31 - i;
         res = 32'(n);
         rec = it.rc;
      end else if (it.op <= OP_MULLW) begin
         p = $signed(gpr[it.ra]) * $signed(it.op == OP_MULLI ? simm : gpr[it.rb]);
         if (it.op == OP_MULHW) begin
            res = p[63:32];
            rec = it.rc;
         end else begin
            res = p[31:0];
            if (it.op == OP_MULLW) begin
               rec = it.rc;
               if (it.oe) begin
                  xov = (p[63:31] != {33{p[31]}});
                  xso |= xov;
               end
            end
         end
      end else if (it.op == OP_NEG) begin
         res = 32'd0 - gpr[it.ra];
         if (it.oe) begin
            xov = (gpr[it.ra] == SIGN_BIT);
            xso |= xov;
         end
         rec = it.rc;
      end else if (it.op <= OP_RLWNM) begin
         n = (it.op == OP_RLWNM) ? int'(gpr[it.rb][4:0]) : int'(it.sh);
         rot = (n == 0) ? gpr[it.ra] : ((gpr[it.ra] << n) | (gpr[it.ra] >> (32 - n)));
         m = rot_mask(it.mb, it.me);
         res = (it.op == OP_RLWIMI) ? ((rot & m) | (gpr[it.rd] & ~m)) : (rot & m);
         rec = it.rc;
      end else begin
         wr = 1'b0;
      end
      if (wr) begin
         gpr[it.rd] = res;
         if (rec)
            cr0 = {res[31], !res[31] && res != 0, res == 0, xso};
      end
      r.written_reg = it.rd;
      r.result = res;
      r.cr0_out = cr0;
      r.so_out = xso;
      r.ov_out = xov;
      r.ca_out = xca;
      r.cr_written = wr && rec;
      return r;
   endfunction

   function automatic logic [31:0] edge_value();
      case ($urandom_range(0, 7))
         0: return 32'd0;
         1: return ALL_ONES;
         2: return SIGN_BIT;
         3: return 32'h7fff_ffff;
         4: return 32'd1;
         default: return $urandom;
      endcase
   endfunction

   task automatic queue_instr(input instr_type it);
      pending_instrs.push_back(it);
   endtask

   function automatic instr_type random_instr(input int unsigned max_op);
      instr_type it;
      it.op = 6'($urandom_range(0, max_op));
      it.rd = 5'($urandom);
      it.ra = 5'($urandom);
      it.rb = 5'($urandom);
      it.imm = ($urandom_range(0, 3) == 0) ? 16'(edge_value()) : 16'($urandom);
      it.sh = 5'($urandom);
      it.mb = 5'($urandom);
      it.me = 5'($urandom);
      it.oe = 1'($urandom);
      it.rc = 1'($urandom);
      return it;
   endfunction

   // seed registers through addis/ori pairs with interesting values
   task automatic load_reg(input logic [4:0] r, input logic [31:0] v);
      instr_type it;
      it = '0;
      it.op = OP_ADDIS; it.rd = r; it.ra = 5'd0; it.imm = v[31:16];
      queue_instr(it);
      it.op = OP_AND + LK_ORI; it.ra = r; it.imm = v[15:0];
      queue_instr(it);
   endtask

   // driver
   int unsigned drv_idle = 0;
   always @(posedge clock) begin
      instr_type nxt;
      if (reset) begin
         push <= 1'b0;
      end else begin
         if (!(push && full)) begin
            if (drv_idle > 0) begin
               drv_idle <= drv_idle - 1;
               push <= 1'b0;
            end else if (!drain_pause && pending_instrs.size() > 0) begin
               nxt = pending_instrs.pop_front();
               drv <= nxt;
               push <= 1'b1;
               expected_writebacks.push_back(execute_instr(nxt));
               if (!calm && $urandom_range(0, 15) == 0)
                  drv_idle <= $urandom_range(1, 16);
            end else begin
               push <= 1'b0;
            end
         end
      end
   end

   // monitor
   int unsigned mon_idle = 0;
   always @(posedge clock) begin
      rsp_type exp_r;
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            if (expected_writebacks.size() == 0) begin
               $display("%0t: unexpected item reg=%0d result=%h", $time,
                        rsp_written_reg, rsp_result);
               errors++;
            end else begin
               exp_r = expected_writebacks.pop_front();
               checked++;
               if (exp_r != {rsp_written_reg, rsp_result, rsp_cr0_out, rsp_so_out,
                             rsp_ov_out, rsp_ca_out, rsp_cr_written}) begin
                  $display("%0t: mismatch expected reg=%0d res=%h cr0=%h so=%b ov=%b ca=%b crw=%b",
                           $time, exp_r.written_reg, exp_r.result, exp_r.cr0_out,
                           exp_r.so_out, exp_r.ov_out, exp_r.ca_out, exp_r.cr_written);
                  $display("%0t:          actual   reg=%0d res=%h cr0=%h so=%b ov=%b ca=%b crw=%b",
                           $time, rsp_written_reg, rsp_result, rsp_cr0_out, rsp_so_out,
                           rsp_ov_out, rsp_ca_out, rsp_cr_written);
                  errors++;
               end
            end
         end
         if (hold_off) begin
            pop <= 1'b0;
         end else if (mon_idle > 0) begin
            mon_idle <= mon_idle - 1;
            pop <= 1'b0;
         end else begin
            pop <= 1'b1;
            if (!calm && $urandom_range(0, 15) == 0)
               mon_idle <= $urandom_range(1, 16);
         end
      end
   end

   // long receiver stall, counted here
   initial begin
      int unsigned n;
      wait (checked >= 300);
      hold_off = 1'b1;
      n = 0;
      while (n < 200) begin
         @(posedge clock);
         n++;
      end
      hold_off = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout with %0d items outstanding", expected_writebacks.size());
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      instr_type it;
      for (int i = 0; i < 32; i++) gpr[i] = '0;
      cr0 = '0; xso = 0; xov = 0; xca = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, carry/overflow corners, wrap mask, zero base
      load_reg(5'd1, 32'h7fff_ffff);
      load_reg(5'd2, SIGN_BIT);
      load_reg(5'd3, ALL_ONES);
      it = '0; it.oe = 1; it.rc = 1;
      it.op = OP_ADD; it.rd = 5'd4; it.ra = 5'd1; it.rb = 5'd1; queue_instr(it);
      it.op = OP_ADDC; it.rd = 5'd5; it.ra = 5'd3; it.rb = 5'd3; queue_instr(it);
      it.op = OP_ADDE; it.rd = 5'd6; it.ra = 5'd2; it.rb = 5'd2; queue_instr(it);
      it.op = OP_ADDI; it.rd = 5'd7; it.ra = 5'd0; it.imm = 16'h8000; queue_instr(it);
      it.op = OP_ADDIC_DOT; it.rd = 5'd8; it.ra = 5'd3; it.imm = 16'd1; queue_instr(it);
      it.op = OP_ADDME; it.rd = 5'd9; it.ra = 5'd2; queue_instr(it);
      it.op = OP_ADDZE; it.rd = 5'd10; it.ra = 5'd1; queue_instr(it);
      it.op = OP_SUBF; it.rd = 5'd11; it.ra = 5'd1; it.rb = 5'd2; queue_instr(it);
      it.op = OP_SUBFIC; it.rd = 5'd12; it.ra = 5'd3; it.imm = 16'hffff; queue_instr(it);
      it.op = OP_NEG; it.rd = 5'd13; it.ra = 5'd2; queue_instr(it);
      it.op = OP_MULLW; it.rd = 5'd14; it.ra = 5'd2; it.rb = 5'd2; queue_instr(it);
      it.op = OP_MULHW; it.rd = 5'd15; it.ra = 5'd2; it.rb = 5'd3; queue_instr(it);
      it.op = OP_CNTLZW; it.rd = 5'd16; it.ra = 5'd0; queue_instr(it);
      it.op = OP_RLWINM; it.rd = 5'd17; it.ra = 5'd3; it.sh = 5'd31;
      it.mb = 5'd28; it.me = 5'd3; queue_instr(it);
      it.op = OP_RLWIMI; it.rd = 5'd1; it.ra = 5'd2; it.sh = 5'd1;
      it.mb = 5'd31; it.me = 5'd31; queue_instr(it);
      it.op = OP_LAST + 6'd1; it.rd = 5'd3; queue_instr(it);
      it.op = 6'h3f; it.rd = 5'd31; queue_instr(it);

      // random: mostly valid ops, a few unused codes, periodic edge loads
      for (int i = 0; i < 1500; i++) begin
         if (i % 40 == 0) load_reg(5'($urandom), edge_value());
         if (i == 1100) begin
            wait (pending_instrs.size() == 0);
            drain_pause = 1'b1;
            wait (expected_writebacks.size() == 0);
            drain_pause = 1'b0;
         end
         if (i == 1300) begin
            wait (pending_instrs.size() == 0);
            calm = 1'b1;
         end
         it = random_instr($urandom_range(0, 19) == 0 ? 63 : OP_LAST);
         if (it.op == OP_ADDIC_DOT || it.rc) dot_count++;
         queue_instr(it);
      end

      wait (pending_instrs.size() == 0 && !push);
      wait (expected_writebacks.size() == 0);
      repeat (20) @(posedge clock);
      $display("Checked %0d results across all 34 operations (%0d with CR0 record), edge operands,",
               checked, dot_count);
      $display("random stalls on both sides, a long receiver hold-off and a drain pause.");
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

[ppc_integer_alu_with_flags_unit.f]
src/iaf_pkg.sv
src/iaf_fifo.sv
src/iaf_ram.sv
src/iaf_front.sv
src/iaf_back.sv
src/ppc_integer_alu_with_flags_unit.sv
tb/tb_ppc_integer_alu_with_flags_unit.sv
